// ===== src/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; define ASSERT_OFF to drop them.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is low
`define ASSERT_CLKRST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Clocked check that also holds during reset
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLKRST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

// ===== src/lmcd_pkg.sv =====
// -----------------------------------------------------------------------------
// lmcd_pkg
// Shared types and constants of the LED matrix circle drawer.
// -----------------------------------------------------------------------------
`default_nettype none
package lmcd_pkg;

    localparam int LMCD_WIDTH  = 16;
    localparam int LMCD_HEIGHT = 16;

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_FILL   = 2'd0,
        OP_PIXEL  = 2'd1,
        OP_CIRCLE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Controller states
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_FILL, S_PIX, S_ARG, S_RA_GO, S_RA_WAIT,
        S_MUL, S_RB_GO, S_RB_WAIT, S_COLOR, S_SMALL, S_WALK, S_ROW, S_CHECK,
        S_READ, S_DONE
    } t_state;

    // Datapath commands
    typedef enum logic [3:0] {
        DP_NONE, DP_LOAD, DP_CLEAR_WR, DP_FILL_WR, DP_PIX_WR, DP_ARG, DP_ROOT_A,
        DP_WAIT_A, DP_MUL, DP_ROOT_B, DP_WAIT_B, DP_COLOR, DP_SMALL_WR,
        DP_WALK_WR, DP_NEXT_ROW, DP_RESULT
    } t_dp_cmd;

    // Datapath status towards the controller
    typedef struct packed {
        t_op  op;
        logic root_done;
        logic last_pix;
        logic last_small;
        logic last_walk;
        logic walk_more;
        logic is_small;
        logic too_large;
        logic out_free;
    } t_dp_sts;

    localparam logic [9:0] SMALL_MAX = 10'd16;
    localparam logic [9:0] LARGE_MAX = 10'd320;
    localparam int         ROOT_BITS = 13;
    localparam int         ROOT_NW   = 28;
    localparam logic [15:0] FRAC_SCALE = 16'd65025;

endpackage
`default_nettype wire

// ===== src/lmcd_root.sv =====
// -----------------------------------------------------------------------------
// lmcd_root
// Iterative search for the largest m with 10*m*m <= n, one bit per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module lmcd_root (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lmcd_pkg::ROOT_NW-1:0]  i_n,
    output logic                               o_done,
    output logic [lmcd_pkg::ROOT_BITS-1:0]     o_m
);
    import lmcd_pkg::*;

    logic                   r_busy, r_done;
    logic [3:0]             r_k;
    logic [ROOT_NW-1:0]     r_n;
    logic [ROOT_BITS-1:0]   r_m;
    logic [ROOT_BITS-1:0]   trial;
    logic [2*ROOT_BITS-1:0] sq;
    logic [2*ROOT_BITS+3:0] t10;

    // Try the current bit on top of the kept bits
    always_comb begin
        trial = r_m | (ROOT_BITS'(1) << r_k);
        sq    = trial * trial;
        t10   = ({4'b0, sq} << 3) + ({4'b0, sq} << 1);
    end

    // Restoring search from the top bit down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 4'(ROOT_BITS - 1);
                r_n    <= i_n;
                r_m    <= '0;
            end else if (r_busy) begin
                if (t10 <= {2'b0, r_n}) begin
                    r_m <= trial;
                end
                if (r_k == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 4'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_m    = r_m;

endmodule
`default_nettype wire

// ===== src/lmcd_ctrl.sv =====
// -----------------------------------------------------------------------------
// lmcd_ctrl
// Sequencer that steps the datapath through each operation.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lmcd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output lmcd_pkg::t_dp_cmd      o_cmd,
    input  wire lmcd_pkg::t_dp_sts i_sts
);
    import lmcd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (i_sts.last_pix) n_state = S_IDLE;
            S_IDLE:     if (i_in_valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_FILL:   n_state = S_FILL;
                    OP_PIXEL:  n_state = S_PIX;
                    OP_CIRCLE: begin
                        if (i_sts.is_small)       n_state = S_COLOR;
                        else if (i_sts.too_large) n_state = S_DONE;
                        else                      n_state = S_ARG;
                    end
                    default:   n_state = S_READ;
                endcase
            end
            S_FILL:     if (i_sts.last_pix) n_state = S_DONE;
            S_PIX:      n_state = S_DONE;
            S_ARG:      n_state = S_RA_GO;
            S_RA_GO:    n_state = S_RA_WAIT;
            S_RA_WAIT:  if (i_sts.root_done) n_state = S_MUL;
            S_MUL:      n_state = S_RB_GO;
            S_RB_GO:    n_state = S_RB_WAIT;
            S_RB_WAIT:  if (i_sts.root_done) n_state = S_COLOR;
            S_COLOR:    n_state = i_sts.is_small ? S_SMALL : S_WALK;
            S_SMALL:    if (i_sts.last_small) n_state = S_DONE;
            S_WALK:     if (i_sts.last_walk) n_state = S_ROW;
            S_ROW:      n_state = S_CHECK;
            S_CHECK:    n_state = i_sts.walk_more ? S_ARG : S_DONE;
            S_READ:     n_state = S_DONE;
            S_DONE:     if (i_sts.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = DP_NONE;
        case (r_state)
            S_CLEAR:   o_cmd = DP_CLEAR_WR;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = DP_LOAD;
            end
            S_FILL:    o_cmd = DP_FILL_WR;
            S_PIX:     o_cmd = DP_PIX_WR;
            S_ARG:     o_cmd = DP_ARG;
            S_RA_GO:   o_cmd = DP_ROOT_A;
            S_RA_WAIT: o_cmd = DP_WAIT_A;
            S_MUL:     o_cmd = DP_MUL;
            S_RB_GO:   o_cmd = DP_ROOT_B;
            S_RB_WAIT: o_cmd = DP_WAIT_B;
            S_COLOR:   o_cmd = DP_COLOR;
            S_SMALL:   o_cmd = DP_SMALL_WR;
            S_WALK:    o_cmd = DP_WALK_WR;
            S_ROW:     o_cmd = DP_NEXT_ROW;
            S_DONE:    if (i_sts.out_free) o_cmd = DP_RESULT;
            default:   o_cmd = DP_NONE;
        endcase
    end

    `ASSERT_CLKRST(a_accept_leaves_idle, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_DISPATCH))
    `ASSERT_CLKRST(a_colour_then_write, i_clk, i_rst_n, (r_state == S_COLOR) |=> (r_state == S_WALK || r_state == S_SMALL))
    `ASSERT_CLKRST(a_root_a_to_mul, i_clk, i_rst_n, (r_state == S_RA_WAIT && i_sts.root_done) |=> (r_state == S_MUL))

endmodule
`default_nettype wire

// ===== src/lmcd_dp.sv =====
// -----------------------------------------------------------------------------
// lmcd_dp
// Frame store, circle arithmetic, write address generation and result register.
// -----------------------------------------------------------------------------
`default_nettype none
module lmcd_dp #(
    parameter int WIDTH  = lmcd_pkg::LMCD_WIDTH,
    parameter int HEIGHT = lmcd_pkg::LMCD_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lmcd_pkg::t_dp_cmd i_cmd,
    output lmcd_pkg::t_dp_sts      o_sts,
    input  wire logic [55:0]       i_data,
    input  wire lmcd_pkg::t_op     i_op,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [23:0]            o_out_data,
    output logic                   o_out_user
);
    import lmcd_pkg::*;

    localparam int PIX = WIDTH * HEIGHT;
    localparam int AW  = $clog2(PIX);
    localparam int CW  = (AW > 4) ? AW : 4;

    logic [23:0] mem [PIX];

    t_op                r_op;
    logic signed [6:0]  r_cx, r_cy;
    logic [9:0]         r_rq;
    logic [23:0]        r_rgb;
    logic [7:0]         r_idx;
    logic [CW-1:0]      r_cnt;
    logic [4:0]         r_dx, r_dy;
    logic [11:0]        r_arg;
    logic [ROOT_NW-1:0] r_nb;
    logic [ROOT_BITS-1:0] r_m;
    logic [23:0]        r_ca, r_cb, r_rd;
    logic               r_ovalid, r_ouser;
    logic [23:0]        r_odata;

    logic                 root_start, root_done;
    logic [ROOT_NW-1:0]   root_n;
    logic [ROOT_BITS-1:0] root_m;

    lmcd_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_n     (root_n),
        .o_done  (root_done),
        .o_m     (root_m)
    );

    assign root_start = (i_cmd == DP_ROOT_A) || (i_cmd == DP_ROOT_B);
    assign root_n     = (i_cmd == DP_ROOT_A) ? ROOT_NW'(r_arg) : r_nb;

    function automatic logic [7:0] sc8(input logic [7:0] c, input logic [7:0] s);
        logic [16:0] p;
        p = c * ({1'b0, s} + 9'd1);
        return p[15:8];
    endfunction

    function automatic logic [23:0] scale(input logic [23:0] rgb, input logic [7:0] s);
        return {sc8(rgb[23:16], s), sc8(rgb[15:8], s), sc8(rgb[7:0], s)};
    endfunction

    // Radius squared less the row term, times ten over 256
    logic [19:0] rq2, dy2s, xdiff;
    logic [23:0] x10;
    always_comb begin
        rq2   = r_rq * r_rq;
        dy2s  = 20'(r_dy * r_dy) << 8;
        xdiff = rq2 - dy2s;
        x10   = ({4'b0, xdiff} << 3) + ({4'b0, xdiff} << 1);
    end

    // Fraction and the two scale factors
    logic [13:0] dx255, fdiff;
    logic [7:0]  f, sa, sb;
    logic [13:0] rq255, rqc255;
    always_comb begin
        dx255  = (14'(r_dx) << 8) - 14'(r_dx);
        fdiff  = {1'b0, r_m} - dx255;
        f      = (fdiff > 14'd255) ? 8'd255 : fdiff[7:0];
        rq255  = (14'(r_rq) << 8) - 14'(r_rq);
        rqc255 = (14'(SMALL_MAX - r_rq) << 8) - 14'(SMALL_MAX - r_rq);
        if (r_rq <= SMALL_MAX) begin
            sa = rq255[11:4];
            sb = rqc255[11:4];
        end else begin
            sa = 8'd255 - f;
            sb = f;
        end
    end

    // Pixel position for the write in hand
    logic signed [8:0] px, py, cx9, cy9, pp, qq;
    logic [5:0]        dxe;
    always_comb begin
        cx9 = 9'(r_cx);
        cy9 = 9'(r_cy);
        dxe = r_cnt[0] ? (6'(r_dx) + 6'd1) : 6'(r_dx);
        pp  = r_cnt[1] ? -$signed(9'(dxe)) : $signed(9'(dxe));
        qq  = r_cnt[2] ? -$signed(9'(r_dy)) : $signed(9'(r_dy));
        px  = cx9;
        py  = cy9;
        case (i_cmd)
            DP_SMALL_WR: begin
                case (r_cnt[2:0])
                    3'd0:    px = cx9 + 9'sd1;
                    3'd1:    px = cx9 - 9'sd1;
                    3'd2:    py = cy9 + 9'sd1;
                    3'd3:    py = cy9 - 9'sd1;
                    default: px = cx9;
                endcase
            end
            DP_WALK_WR: begin
                if (!r_cnt[3]) begin
                    px = cx9 + pp;
                    py = cy9 + qq;
                end else begin
                    px = cx9 + qq;
                    py = cy9 + pp;
                end
            end
            default: px = cx9;
        endcase
    end

    // Clip and map to serpentine strip order
    logic        on_screen;
    logic [31:0] xs, ys, wr_full, idx32;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [23:0]   wr_data;
    logic          wr_en;
    always_comb begin
        xs        = 32'(px[7:0]);
        ys        = 32'(py[7:0]);
        on_screen = !px[8] && !py[8] && (xs < WIDTH) && (ys < HEIGHT);
        wr_full   = ys * WIDTH + (ys[0] ? xs : (WIDTH - 1 - xs));
        idx32     = 32'(r_idx);
        rd_addr   = idx32[AW-1:0];
        wr_addr   = wr_full[AW-1:0];
        wr_data   = r_rgb;
        wr_en     = 1'b0;
        case (i_cmd)
            DP_CLEAR_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[AW-1:0];
                wr_data = '0;
            end
            DP_FILL_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[AW-1:0];
            end
            DP_PIX_WR:   wr_en = on_screen;
            DP_SMALL_WR: begin
                wr_en   = on_screen;
                wr_data = (r_cnt[2:0] == 3'd4) ? r_cb : r_ca;
            end
            DP_WALK_WR: begin
                wr_en   = on_screen;
                wr_data = r_cnt[0] ? r_cb : r_ca;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Frame store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    // Item registers and circle arithmetic
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LOAD: begin
                r_op  <= i_op;
                r_cx  <= i_data[6:0];
                r_cy  <= i_data[13:7];
                r_rq  <= i_data[23:14];
                r_rgb <= i_data[47:24];
                r_idx <= i_data[55:48];
                r_dy  <= '0;
                r_dx  <= i_data[22:18];
            end
            DP_ARG:    r_arg <= x10[19:8];
            DP_WAIT_A: if (root_done) r_dx <= root_m[4:0];
            DP_MUL:    r_nb <= ROOT_NW'(r_arg * FRAC_SCALE);
            DP_WAIT_B: if (root_done) r_m <= root_m;
            DP_COLOR: begin
                r_ca <= scale(r_rgb, sa);
                r_cb <= scale(r_rgb, sb);
            end
            DP_NEXT_ROW: r_dy <= r_dy + 5'd1;
            default: r_dy <= r_dy;
        endcase
    end

    // Write counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (i_cmd)
                DP_LOAD, DP_NEXT_ROW, DP_COLOR: r_cnt <= '0;
                DP_CLEAR_WR, DP_FILL_WR, DP_SMALL_WR, DP_WALK_WR: r_cnt <= r_cnt + 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd == DP_RESULT) begin
            r_ovalid <= 1'b1;
            r_ouser  <= (r_op == OP_READ);
            r_odata  <= (r_op == OP_READ && idx32 < PIX) ? r_rd : '0;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_user  = r_ouser;

    always_comb begin
        o_sts.op         = r_op;
        o_sts.root_done  = root_done;
        o_sts.last_pix   = (32'(r_cnt) == PIX - 1);
        o_sts.last_small = (r_cnt[2:0] == 3'd4);
        o_sts.last_walk  = (r_cnt[3:0] == 4'd15);
        o_sts.walk_more  = (r_dy < r_dx);
        o_sts.is_small   = (r_rq <= SMALL_MAX);
        o_sts.too_large  = (r_rq > LARGE_MAX);
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

endmodule
`default_nettype wire

// ===== src/led_matrix_circle_drawer_unit.sv =====
// -----------------------------------------------------------------------------
// led_matrix_circle_drawer_unit
// Serpentine LED frame buffer with fill, set, antialiased circle and read.
// -----------------------------------------------------------------------------
// One item is taken at a time and returns one beat. After reset the frame
// store is cleared to black, during which no item is accepted. Fill writes
// the pixels one after another through the single write port of the frame
// store. A circle of radius up to one pixel is drawn without the square-root
// unit; larger circles are drawn by row steps (up to 20 steps), each with two
// passes of the 13-step square-root unit and sixteen frame-store writes. A
// finished beat waits in an output register, so the next item is taken while
// it is still pending.
`default_nettype none
module led_matrix_circle_drawer_unit #(
    parameter int WIDTH  = lmcd_pkg::LMCD_WIDTH,
    parameter int HEIGHT = lmcd_pkg::LMCD_HEIGHT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pos_x[6:0], pos_y[13:7], radius[23:14], red[31:24], green[39:32],
    // blue[47:40], strip_index[55:48]
    input  wire logic [55:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_red[7:0], read_green[15:8], read_blue[23:16]
    output logic [23:0]      m_axis_tdata,
    // is_read[0]
    output logic             m_axis_tuser
);
    import lmcd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    lmcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    lmcd_dp #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_data      (s_axis_tdata),
        .i_op        (t_op'(s_axis_tuser)),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== dv/lmcd_checker.sv =====
// -----------------------------------------------------------------------------
// lmcd_checker
// Watches both streams of the circle drawer, models the frame store and
// compares every output beat with the predicted beat and its read flag.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module lmcd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [55:0] i_in_data,
    input  wire logic [1:0]  i_in_user,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [23:0] i_out_data,
    input  wire logic        i_out_user,
    output int               o_fail_count,
    output int               o_pending
);
    import lmcd_pkg::*;

    localparam int PIXELS = LMCD_WIDTH * LMCD_HEIGHT;

    typedef struct packed {
        logic [23:0] rgb;
        logic        is_read;
    } t_read_beat;

    logic [23:0] pixel_mem [PIXELS];
    t_read_beat  read_beats_q [$];

    assign o_pending = read_beats_q.size();

    function automatic logic [7:0] scale_chan(logic [7:0] c, int s);
        return 8'((int'(c) * (s + 1)) >> 8);
    endfunction

    function automatic logic [23:0] scale_rgb(logic [23:0] rgb, int s);
        return {scale_chan(rgb[23:16], s), scale_chan(rgb[15:8], s),
                scale_chan(rgb[7:0], s)};
    endfunction

    function automatic int root_tenth(longint n);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = 8191;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (10 * longint'(mid) * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    task automatic plot(int x, int y, logic [23:0] rgb);
        if (x < 0 || x >= LMCD_WIDTH || y < 0 || y >= LMCD_HEIGHT) return;
        if (y % 2 == 0) pixel_mem[y * LMCD_WIDTH + (LMCD_WIDTH - 1 - x)] = rgb;
        else pixel_mem[y * LMCD_WIDTH + x] = rgb;
    endtask

    task automatic draw_ring(int cx, int cy, int rq, logic [23:0] rgb);
        int dy;
        int dx;
        int f;
        longint arg;
        logic [23:0] ca;
        logic [23:0] cb;
        if (rq <= 16) begin
            ca = scale_rgb(rgb, (255 * rq) / 16);
            cb = scale_rgb(rgb, (255 * (16 - rq)) / 16);
            plot(cx + 1, cy, ca);
            plot(cx - 1, cy, ca);
            plot(cx, cy + 1, ca);
            plot(cx, cy - 1, ca);
            plot(cx, cy, cb);
            return;
        end
        if (rq > 320) return;
        dy = 0;
        dx = rq >> 4;
        while (dy < dx) begin
            arg = (10 * (longint'(rq) * rq - 256 * dy * dy)) / 256;
            dx = root_tenth(arg);
            f = root_tenth(65025 * arg) - 255 * dx;
            if (f > 255) f = 255;
            ca = scale_rgb(rgb, 255 - f);
            cb = scale_rgb(rgb, f);
            plot(cx + dx, cy + dy, ca);
            plot(cx + 1 + dx, cy + dy, cb);
            plot(cx - dx, cy + dy, ca);
            plot(cx - 1 - dx, cy + dy, cb);
            plot(cx + dx, cy - dy, ca);
            plot(cx + 1 + dx, cy - dy, cb);
            plot(cx - dx, cy - dy, ca);
            plot(cx - 1 - dx, cy - dy, cb);
            plot(cx + dy, cy + dx, ca);
            plot(cx + dy, cy + 1 + dx, cb);
            plot(cx + dy, cy - dx, ca);
            plot(cx + dy, cy - 1 - dx, cb);
            plot(cx - dy, cy + dx, ca);
            plot(cx - dy, cy + 1 + dx, cb);
            plot(cx - dy, cy - dx, ca);
            plot(cx - dy, cy - 1 - dx, cb);
            dy++;
        end
    endtask

    // Apply one accepted command to the frame model, queue its beat
    task automatic apply_command(logic [55:0] d, t_op op);
        t_read_beat beat;
        logic [23:0] rgb;
        // Keep red in the low byte, as the output beat carries it
        rgb = d[47:24];
        beat = '0;
        case (op)
            OP_FILL: begin
                foreach (pixel_mem[i]) pixel_mem[i] = rgb;
            end
            OP_PIXEL: plot(int'($signed(d[6:0])), int'($signed(d[13:7])), rgb);
            OP_CIRCLE: draw_ring(int'($signed(d[6:0])), int'($signed(d[13:7])),
                                 int'(d[23:14]), rgb);
            default: begin
                beat.is_read = 1'b1;
                if (int'(d[55:48]) < PIXELS) beat.rgb = pixel_mem[d[55:48]];
            end
        endcase
        read_beats_q.push_back(beat);
    endtask

    initial begin
        foreach (pixel_mem[i]) pixel_mem[i] = '0;
    end

    // Predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_read_beat want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) apply_command(i_in_data, t_op'(i_in_user));
            if (i_out_valid && i_out_ready) begin
                if (read_beats_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected beat: data %h user %b", i_out_data,
                                 i_out_user);
                end else begin
                    want = read_beats_q.pop_front();
                    if (want.rgb !== i_out_data || want.is_read !== i_out_user) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: want rgb %h read %b, got rgb %h read %b",
                                     want.rgb, want.is_read, i_out_data, i_out_user);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// -----------------------------------------------------------------------------
// tb
// Stimulus for the circle drawer: directed corners, then random commands,
// mostly circles and reads over the visible frame, across idle phases.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import lmcd_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int STALL_LIMIT  = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // pos_x, pos_y, radius, red, green, blue, strip_index
    logic [55:0] s_axis_tdata = '0;
    // op
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // read_red, read_green, read_blue
    logic [23:0] m_axis_tdata;
    // is_read
    logic        m_axis_tuser;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    led_matrix_circle_drawer_unit dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    lmcd_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no beat accepted; the clear pass counts too
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one command beat and hold it until taken; drop valid only when idling
    task automatic send(t_op op, int x, int y, int rq, logic [23:0] rgb, int idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {8'(idx), rgb[7:0], rgb[15:8], rgb[23:16], 10'(rq),
                          7'(y), 7'(x)};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Random command, biased towards visible positions and real circles
    task automatic send_random();
        int sel;
        int x;
        int y;
        int rq;
        sel = $urandom_range(99);
        x = ($urandom_range(9) == 0) ? $urandom_range(127) - 64 : $urandom_range(19) - 2;
        y = ($urandom_range(9) == 0) ? $urandom_range(127) - 64 : $urandom_range(19) - 2;
        case ($urandom_range(9))
            0: rq = $urandom_range(1023);
            1, 2: rq = $urandom_range(16);
            default: rq = $urandom_range(320, 17);
        endcase
        if (sel < 3)
            send(OP_FILL, x, y, rq, 24'($urandom), $urandom_range(255));
        else if (sel < 25)
            send(OP_PIXEL, x, y, rq, 24'($urandom), $urandom_range(255));
        else if (sel < 45)
            send(OP_CIRCLE, x, y, rq, 24'($urandom), $urandom_range(255));
        else
            send(OP_READ, $urandom_range(127) - 64, $urandom_range(127) - 64,
                 $urandom_range(1023), 24'($urandom), $urandom_range(255));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: every op, clipping, small/large/too-large circles
        send(OP_READ, 0, 0, 0, 24'h0, 0);
        send(OP_FILL, -64, 63, 1023, 24'hFFFFFF, 255);
        send(OP_READ, 0, 0, 0, 24'h0, 255);
        send(OP_PIXEL, 0, 0, 0, 24'h123456, 0);
        send(OP_PIXEL, 15, 15, 0, 24'hABCDEF, 0);
        send(OP_PIXEL, -64, 63, 0, 24'h000000, 0);
        send(OP_PIXEL, 16, 5, 0, 24'h000000, 0);
        send(OP_READ, 0, 0, 0, 24'h0, 15);
        send(OP_READ, 0, 0, 0, 24'h0, 255);
        send(OP_FILL, 0, 0, 0, 24'h000000, 0);
        send(OP_CIRCLE, 7, 7, 0, 24'hFF8040, 0);
        send(OP_CIRCLE, 3, 3, 16, 24'hFFFFFF, 0);
        send(OP_CIRCLE, 0, 0, 8, 24'h80FF01, 0);
        send(OP_CIRCLE, 8, 8, 17, 24'hFFFFFF, 0);
        send(OP_CIRCLE, 8, 8, 320, 24'hFFFFFF, 0);
        send(OP_CIRCLE, 8, 8, 321, 24'hFFFFFF, 0);
        send(OP_CIRCLE, -64, -64, 1023, 24'hFFFFFF, 0);
        send(OP_CIRCLE, 63, 63, 100, 24'hFFFFFF, 0);
        send(OP_READ, 0, 0, 0, 24'h0, 136);
        send(OP_READ, 0, 0, 0, 24'h0, 119);
        send(OP_READ, 0, 0, 0, 24'h0, 0);

        // Random phases: none, sender idle, receiver stall, both light
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  <= (ph == 1) ? 75 : (ph == 3) ? 6 : 0;
            recv_stall_pct <= (ph == 2) ? 75 : (ph == 3) ? 6 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_random();
        end

        // Long receiver hold-off while commands keep coming
        fork
            begin
                hold_off <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            for (int n = 0; n < 10; n++) send(OP_READ, 0, 0, 0, 24'h0, $urandom_range(255));
        join
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
